[hdl/quaternion_to_euler_angles_core_defines.svh]
// shared assertion macros for the quaternion to euler angles core
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// same-cycle implication, sampled on the core clock
`define QTE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("quaternion_to_euler_angles_core: assertion failed");

// next-cycle implication, sampled on the core clock
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("quaternion_to_euler_angles_core: assertion failed");

`endif

[hdl/qte_pkg.sv]
package qte_pkg;

   localparam int CORDIC_STAGES_DEF = 16;

   localparam int Q_W        = 16;  // input component width
   localparam int A_W        = 16;  // output angle width
   localparam int PROD_W     = 32;
   localparam int SUM_W      = 36;  // atan2 operands, scale 2^28
   localparam int S_W        = 30;  // clamped pitch sine
   localparam int SU_W       = 29;  // magnitude of pitch sine
   localparam int N_W        = 57;  // radicand 2^56 - s^2
   localparam int R_W        = 58;  // square root remainder and result
   localparam int SQRT_STEPS = 29;
   localparam int CW         = 38;  // cordic datapath
   localparam int ANG_W      = 32;  // angle accumulator, 2^32 = 2*pi

   localparam logic signed [SUM_W-1:0] ONE_Q28 = 36'sh010000000;
   localparam logic signed [SUM_W-1:0] NEG_ONE_Q28 = -36'sh010000000;
   localparam logic [R_W-1:0] ONE_Q56 = 58'h100000000000000;

   localparam logic [ANG_W-1:0] ANG_QUARTER = 32'h4000_0000;
   localparam logic [ANG_W-1:0] ANG_THREE_Q = 32'hC000_0000;
   localparam logic [ANG_W-1:0] ANG_ROUND   = 32'h0000_8000;
   localparam logic [A_W-1:0]   PITCH_UP    = 16'h4000;
   localparam logic [A_W-1:0]   PITCH_DOWN  = 16'hC000;

   localparam logic [ANG_W-1:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic signed [SUM_W-1:0] rn;
      logic signed [SUM_W-1:0] rd;
      logic signed [SUM_W-1:0] yn;
      logic signed [SUM_W-1:0] yd;
      logic signed [S_W-1:0]   s;
   } side_type;

   typedef struct packed {
      logic [R_W-1:0] rem;
      logic [R_W-1:0] res;
   } root_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic [ANG_W-1:0]     z;
      logic                 ovr;
      logic [A_W-1:0]       ovr_val;
   } lane_type;

   // quadrant fold ahead of the vectoring iterations
   function automatic lane_type cordic_pre(input logic signed [SUM_W-1:0] y_in,
                                           input logic signed [SUM_W-1:0] x_in);
      logic signed [CW-1:0] xe;
      logic signed [CW-1:0] ye;
      lane_type l;
      xe = $signed({{(CW-SUM_W){x_in[SUM_W-1]}}, x_in});
      ye = $signed({{(CW-SUM_W){y_in[SUM_W-1]}}, y_in});
      l.x = xe;
      l.y = ye;
      l.z = '0;
      l.ovr = 1'b0;
      l.ovr_val = '0;
      if (xe == '0 && ye == '0) begin
         l.ovr = 1'b1;
      end else if (xe < 0) begin
         if (ye >= 0) begin
            l.x = ye;
            l.y = -xe;
            l.z = ANG_QUARTER;
         end else begin
            l.x = -ye;
            l.y = xe;
            l.z = ANG_THREE_Q;
         end
      end
      return l;
   endfunction

endpackage

[hdl/qte_front.sv]
module qte_front
   import qte_pkg::*;
(
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [Q_W-1:0] q_w,
   input  logic signed [Q_W-1:0] q_x,
   input  logic signed [Q_W-1:0] q_y,
   input  logic signed [Q_W-1:0] q_z,
   output side_type              side_out,
   output root_type              root_out
);

   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;
   side_type                 sum_ff, sum_in;
   logic [SU_W-1:0]          su_ff, su_in;
   side_type                 side_ff;
   logic [R_W-1:0]           sq_ff;

   function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
      return $signed({{(SUM_W-PROD_W){p[PROD_W-1]}}, p});
   endfunction

   // products
   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= q_w * q_x;
         yz_ff <= q_y * q_z;
         xx_ff <= q_x * q_x;
         yy_ff <= q_y * q_y;
         wz_ff <= q_w * q_z;
         xy_ff <= q_x * q_y;
         zz_ff <= q_z * q_z;
         wy_ff <= q_w * q_y;
         xz_ff <= q_x * q_z;
      end
   end

   // sums and pitch sine clamp
   always_comb begin
      logic signed [SUM_W-1:0] s_raw;
      logic signed [SUM_W-1:0] s_cl;
      logic signed [SUM_W-1:0] s_abs;
      sum_in.rn = (ext(wx_ff) + ext(yz_ff)) <<< 1;
      sum_in.rd = ONE_Q28 - ((ext(xx_ff) + ext(yy_ff)) <<< 1);
      sum_in.yn = (ext(wz_ff) + ext(xy_ff)) <<< 1;
      sum_in.yd = ONE_Q28 - ((ext(yy_ff) + ext(zz_ff)) <<< 1);
      s_raw = (ext(wy_ff) - ext(xz_ff)) <<< 1;
      if (s_raw > ONE_Q28) begin
         s_cl = ONE_Q28;
      end else if (s_raw < NEG_ONE_Q28) begin
         s_cl = NEG_ONE_Q28;
      end else begin
         s_cl = s_raw;
      end
      sum_in.s = s_cl[S_W-1:0];
      s_abs = (s_cl < 0) ? -s_cl : s_cl;
      su_in = s_abs[SU_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         su_ff  <= su_in;
      end
   end

   // square of the sine
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= sum_ff;
         sq_ff   <= R_W'(su_ff * su_ff);
      end
   end

   assign side_out     = side_ff;
   assign root_out.rem = ONE_Q56 - sq_ff;
   assign root_out.res = '0;

endmodule

[hdl/qte_sqrt_step.sv]
module qte_sqrt_step
   import qte_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic     clock,
   input  logic     en,
   input  root_type root_in,
   output root_type root_out
);

   localparam logic [R_W-1:0] BIT = R_W'(1) << (N_W - 1 - 2 * STEP);

   root_type root_ff, root_in_nxt;

   always_comb begin
      logic [R_W:0] trial;
      trial = {1'b0, root_in.res} + {1'b0, BIT};
      if ({1'b0, root_in.rem} >= trial) begin
         root_in_nxt.rem = root_in.rem - trial[R_W-1:0];
         root_in_nxt.res = (root_in.res >> 1) + BIT;
      end else begin
         root_in_nxt.rem = root_in.rem;
         root_in_nxt.res = root_in.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff <= root_in_nxt;
      end
   end

   assign root_out = root_ff;

endmodule

[hdl/qte_cordic_step.sv]
module qte_cordic_step
   import qte_pkg::*;
#(
   parameter int STEP = 0
)
(
   input  logic     clock,
   input  logic     en,
   input  lane_type lane_in,
   output lane_type lane_out
);

   lane_type lane_ff, lane_nxt;

   always_comb begin
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] yv;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      xv = lane_in.x;
      yv = lane_in.y;
      dx = yv >>> STEP;
      dy = xv >>> STEP;
      lane_nxt = lane_in;
      if (yv >= 0) begin
         lane_nxt.x = xv + dx;
         lane_nxt.y = yv - dy;
         lane_nxt.z = lane_in.z + ATAN_TAB[STEP];
      end else begin
         lane_nxt.x = xv - dx;
         lane_nxt.y = yv + dy;
         lane_nxt.z = lane_in.z - ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_nxt;
      end
   end

   assign lane_out = lane_ff;

endmodule

[hdl/quaternion_to_euler_angles_core.sv]
// quaternion to euler angles (roll, pitch, yaw)
// input channel req_*: one attitude quaternion per transfer, signed q1.14
// (16384 = 1.0), no normalisation applied
// result channel rsp_*: roll and yaw as binary angles (32768 = pi, wrapping),
// pitch as the clamped arcsine (16384 = pi/2)
// stages from input transfer to result valid: registers for products, sums
// and the sine square, 29 square root steps for the pitch cosine, one quadrant
// fold, CORDIC_STAGES vectoring steps, one rounding register
// throughput: one quaternion per cycle unless stalled; every step is its own
// register stage and roll, pitch and yaw each run on their own cordic lane
// reset clears every valid bit; data registers are left as they are
// when the receiver stalls the whole pipeline holds, req_tready drops, and
// the waiting result stays on rsp_tdata until it is taken
// an empty output register still lets the pipeline advance while
// rsp_tready is low; bubbles further up are not squeezed out
`include "quaternion_to_euler_angles_core_defines.svh"

module quaternion_to_euler_angles_core
   import qte_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // roll_angle, pitch_angle, yaw_angle
);

   localparam int FRONT_LAT = 3;
   localparam int LAT = FRONT_LAT + SQRT_STEPS + 1 + CORDIC_STAGES + 1;

   // pipeline advance: the output slot is free or being emptied
   logic adv;
   logic req_accept;
   logic [LAT-1:0] vld_ff, vld_in;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   assign vld_in = {vld_ff[LAT-2:0], req_accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // products, sums, pitch sine squared
   side_type side_front;
   root_type root_front;

   qte_front u_front (
      .clock    (clock),
      .en       (adv),
      .q_w      ($signed(req_tdata[15:0])),
      .q_x      ($signed(req_tdata[31:16])),
      .q_y      ($signed(req_tdata[47:32])),
      .q_z      ($signed(req_tdata[63:48])),
      .side_out (side_front),
      .root_out (root_front)
   );

   // pitch cosine square root, one result bit per stage; the atan2
   // operands of roll and yaw ride alongside
   root_type root_pipe [SQRT_STEPS+1];
   side_type side_pipe [SQRT_STEPS+1];

   assign root_pipe[0] = root_front;
   assign side_pipe[0] = side_front;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      side_type side_ff;

      qte_sqrt_step #(.STEP(k)) u_step (
         .clock    (clock),
         .en       (adv),
         .root_in  (root_pipe[k]),
         .root_out (root_pipe[k+1])
      );

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff <= side_pipe[k];
         end
      end

      assign side_pipe[k+1] = side_ff;
   end

   // quadrant fold for all three lanes; a zero cosine means pitch sits on
   // the clamp limit and gets a fixed answer
   side_type                side_end;
   logic [SU_W-1:0]         cos_val;
   logic signed [SUM_W-1:0] pitch_y, pitch_x;
   lane_type                fold_in [3];
   lane_type                fold_ff [3];

   assign side_end = side_pipe[SQRT_STEPS];
   assign cos_val  = root_pipe[SQRT_STEPS].res[SU_W-1:0];
   assign pitch_y  = $signed({{(SUM_W-S_W){side_end.s[S_W-1]}}, side_end.s});
   assign pitch_x  = $signed({{(SUM_W-SU_W){1'b0}}, cos_val});

   always_comb begin
      fold_in[0] = cordic_pre(side_end.rn, side_end.rd);
      fold_in[2] = cordic_pre(side_end.yn, side_end.yd);
      fold_in[1] = cordic_pre(pitch_y, pitch_x);
      if (cos_val == '0) begin
         fold_in[1].ovr     = 1'b1;
         fold_in[1].ovr_val = (side_end.s > 0) ? PITCH_UP : PITCH_DOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fold_ff <= fold_in;
      end
   end

   // vectoring cordic lanes: roll, pitch, yaw
   lane_type lane_pipe [3][CORDIC_STAGES+1];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign lane_pipe[l][0] = fold_ff[l];
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
         qte_cordic_step #(.STEP(i)) u_step (
            .clock    (clock),
            .en       (adv),
            .lane_in  (lane_pipe[l][i]),
            .lane_out (lane_pipe[l][i+1])
         );
      end
   end

   // rounding to 16-bit binary angles, half up, wrapping
   function automatic logic [A_W-1:0] to_angle(input lane_type l);
      logic [ANG_W-1:0] zr;
      zr = l.z + ANG_ROUND;
      return l.ovr ? l.ovr_val : zr[ANG_W-1:ANG_W-A_W];
   endfunction

   logic [47:0] rsp_data_ff, rsp_data_in;

   assign rsp_data_in = {to_angle(lane_pipe[2][CORDIC_STAGES]),
                         to_angle(lane_pipe[1][CORDIC_STAGES]),
                         to_angle(lane_pipe[0][CORDIC_STAGES])};

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = rsp_data_ff;

   // pitch never leaves plus or minus a quarter turn
   `QTE_ASSERT_NOW(a_pitch_range, rsp_tvalid,
      ($signed(rsp_tdata[31:16]) >= -16'sd16384) && ($signed(rsp_tdata[31:16]) <= 16'sd16384))
   // a stalled output freezes the whole valid chain
   `QTE_ASSERT_NEXT(a_stall_freezes, rsp_tvalid && !rsp_tready, $stable(vld_ff))
   // nothing is taken in while the full pipeline is stalled
   `QTE_ASSERT_NOW(a_no_take_on_stall, rsp_tvalid && !rsp_tready, !req_tready)

endmodule

[verif/quaternion_to_euler_angles_core_test.sv]
module quaternion_to_euler_angles_core_test;
   import qte_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STAGES      = CORDIC_STAGES_DEF;
   localparam int LATENCY     = STAGES + 34;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct packed {
      logic signed [15:0] z;
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic signed [15:0] w;
   } quat_t;

   typedef struct packed {
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
   } euler_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // quat_w, quat_x, quat_y, quat_z
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // roll_angle, pitch_angle, yaw_angle

   int error_count = 0;
   int cycle_count = 0;
   int results_seen = 0;
   bit hold_receiver = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, $signed(got),
               $signed(want), cycle_count);
      error_count++;
   endtask

   // arithmetic shift right of a 64-bit signed value
   function automatic longint shr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // vectoring cordic, 2^32 = 2*pi accumulator, rounded to a 16-bit angle
   function automatic logic [15:0] vector_angle(input longint yv, input longint xv);
      logic [31:0] acc;
      longint      t;
      longint      dx;
      longint      dy;
      acc = '0;
      if (xv == 0 && yv == 0) return 16'h0;
      if (xv < 0) begin
         if (yv >= 0) begin
            t = xv; xv = yv; yv = -t; acc = ANG_QUARTER;
         end else begin
            t = xv; xv = -yv; yv = t; acc = ANG_THREE_Q;
         end
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = shr(yv, i);
         dy = shr(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; acc += ATAN_TAB[i];
         end else begin
            xv -= dx; yv += dy; acc -= ATAN_TAB[i];
         end
      end
      acc += ANG_ROUND;
      return acc[31:16];
   endfunction

   function automatic euler_t attitude_angles(input quat_t q);
      longint w, x, y, z, rn, rd, yn, yd, s, one;
      longint unsigned su, c;
      euler_t e;
      one = 64'sd1 << 28;
      w = q.w; x = q.x; y = q.y; z = q.z;
      rn = 2 * (w * x + y * z);
      rd = one - 2 * (x * x + y * y);
      yn = 2 * (w * z + x * y);
      yd = one - 2 * (y * y + z * z);
      s  = 2 * (w * y - x * z);
      if (s > one) s = one;
      if (s < -one) s = -one;
      su = (s < 0) ? -s : s;
      c = root_floor((64'd1 << 56) - su * su);
      if (c == 0) e.pitch = (s > 0) ? PITCH_UP : PITCH_DOWN;
      else e.pitch = vector_angle(s, longint'(c));
      e.roll = vector_angle(rn, rd);
      e.yaw  = vector_angle(yn, yd);
      return e;
   endfunction

   class angle_scoreboard;
      euler_t pending_angles[$];

      function void note_quaternion(input quat_t q);
         pending_angles.push_back(attitude_angles(q));
      endfunction

      task check_angles(input euler_t got);
         euler_t want;
         if (pending_angles.size() == 0) begin
            $display("result with no quaternion outstanding at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = pending_angles.pop_front();
            if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
            if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
            if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
         end
      endtask
   endclass

   angle_scoreboard board = new();

   quaternion_to_euler_angles_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b0; #1;
      clock = 1'b1; #1;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: check each transfer against the scoreboard and count it
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_angles(euler_t'(rsp_tdata));
         results_seen++;
      end
   end

   // receiver: random stall per result, none for the first 50 of every 200, or a long hold when asked
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_receiver) begin
            rsp_tready <= 1'b0;
            repeat (LATENCY * 3) @(posedge clock);
            hold_receiver = 0;
         end
         gap = (results_seen % 200 < 50) ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
      end
   end

   // offer one quaternion, wait for its transfer, leave valid high
   task automatic send_quaternion(input quat_t q, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= q;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_quaternion(q);
   endtask

   function automatic quat_t mk(input int w, input int x, input int y, input int z);
      quat_t q;
      q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
      return q;
   endfunction

   // near-unit quaternion with random direction, the usual attitude input
   function automatic quat_t unit_ish();
      real a, b, c, d, n;
      a = $signed($urandom_range(0, 65535)) - 32768.0;
      b = $signed($urandom_range(0, 65535)) - 32768.0;
      c = $signed($urandom_range(0, 65535)) - 32768.0;
      d = $signed($urandom_range(0, 65535)) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      return mk(int'(a * 16384.0 / n) + $urandom_range(0, 6) - 3,
                int'(b * 16384.0 / n), int'(c * 16384.0 / n), int'(d * 16384.0 / n));
   endfunction

   initial begin
      quat_t directed[$];
      quat_t q;
      int    sel;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // identity, zero, extremes, gimbal lock both ways, pitch beyond the clamp,
      // angle exactly pi, unnormalised inputs
      directed = '{mk(16384, 0, 0, 0), mk(0, 0, 0, 0), mk(-32768, -32768, -32768, -32768),
                   mk(32767, 32767, 32767, 32767), mk(11585, 0, 11585, 0),
                   mk(11585, 0, -11585, 0), mk(32767, 0, 32767, 0),
                   mk(32767, 0, -32768, 0), mk(0, 16384, 0, 0), mk(0, 0, 0, 16384),
                   mk(0, 0, 16384, 0), mk(-16384, 0, 0, 0), mk(11585, 11585, 0, 0),
                   mk(11585, 0, 0, -11585), mk(-32768, 32767, 0, 0),
                   mk(32767, -32768, -32768, 32767), mk(1, -1, 1, -1),
                   mk(0, 32767, 32767, 0), mk(8192, 8192, 8192, 8192),
                   mk(8192, -8192, 8192, -8192)};
      foreach (directed[i]) send_quaternion(directed[i], $urandom_range(0, 6));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) begin
            // receiver holds off while the sender keeps pushing
            hold_receiver = 1;
         end
         if (n == 600) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (board.pending_angles.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 9);
         if (sel < 6) q = unit_ish();
         else if (sel < 9) q = quat_t'({$urandom(), $urandom()});
         else q = mk(($urandom_range(0, 1) ? 32767 : -32768), $urandom_range(0, 1) << 14,
                     ($urandom_range(0, 1) ? 32767 : -32768), 0);
         send_quaternion(q, (n >= 400 && n < 500) ? 0 : $urandom_range(0, 6));
      end
      req_tvalid <= 1'b0;

      while (board.pending_angles.size() != 0) @(posedge clock);
      repeat (LATENCY * 2) @(posedge clock);

      $display("covered %0d quaternions: identity, zero, gimbal lock, clamped pitch,",
               results_seen);
      $display("near-unit and raw random input, with stalls on both sides");
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_sqrt_step.sv
hdl/qte_cordic_step.sv
hdl/quaternion_to_euler_angles_core.sv
verif/quaternion_to_euler_angles_core_test.sv
